### sv/yuv_to_argb_with_brightness_check_macros.svh
// Assertion macros used by the back end of the YUV to ARGB converter.
`ifndef YUV_TO_ARGB_WITH_BRIGHTNESS_CHECK_MACROS_SVH
`define YUV_TO_ARGB_WITH_BRIGHTNESS_CHECK_MACROS_SVH

// Implication checked in the same cycle; uses the module's clock and reset.
`define YTA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent.
`define YTA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/yta_pkg.sv
// Shared types, constants and helpers of the YUV to ARGB converter.
package yta_pkg;

   // Default geometry limits
   localparam int MAX_WIDTH_DEFAULT  = 4096;
   localparam int MAX_HEIGHT_DEFAULT = 4096;

   // Field widths
   localparam int DIM_W    = 13;
   localparam int LIMIT_W  = 8;
   localparam int SAMPLE_W = 8;
   localparam int ARGB_W   = 32;
   localparam int MEAN_W   = 8;
   localparam int SAMPLE_MAX = 255;

   // Register port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DARK_LIMIT   = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHT_LIMIT = 4'd3;

   // Register reset values
   localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd480;
   localparam logic [LIMIT_W-1:0] DARK_RESET   = 8'd32;
   localparam logic [LIMIT_W-1:0] BRIGHT_RESET = 8'd223;

   // Color math, Q2.14 coefficients
   localparam int OFFS_W = 10;
   localparam int PROD_W = 25;
   localparam int ACC_W  = 27;
   localparam int FRAC_W = 14;
   localparam logic signed [OFFS_W-1:0] LUMA_OFFSET   = 10'sd16;
   localparam logic signed [OFFS_W-1:0] CHROMA_OFFSET = 10'sd128;
   localparam logic signed [PROD_W-1:0] COEF_Y  = 25'sd19078;
   localparam logic signed [PROD_W-1:0] COEF_RV = 25'sd26149;
   localparam logic signed [PROD_W-1:0] COEF_GU = 25'sd6419;
   localparam logic signed [PROD_W-1:0] COEF_GV = 25'sd13320;
   localparam logic signed [PROD_W-1:0] COEF_BU = 25'sd33050;
   localparam logic [7:0] ALPHA    = 8'hff;
   localparam logic [7:0] CHAN_MAX = 8'd255;

   // Queue between front and back
   localparam int FIFO_DEPTH = 4;

   typedef struct packed {
      logic [SAMPLE_W-1:0] luma;
      logic [SAMPLE_W-1:0] chroma_blue;
      logic [SAMPLE_W-1:0] chroma_red;
   } pixel_type;

   typedef struct packed {
      logic row_end;
      logic frame_end;
   } pos_type;

   typedef enum logic [1:0] {
      BS_RUN,
      BS_ROW_DIV,
      BS_FRAME_DIV,
      BS_EMIT
   } back_state_type;

   // Negative gives 0, else drop the fraction and saturate at 255
   function automatic logic [7:0] clamp_channel(input logic signed [ACC_W-1:0] acc);
      logic [ACC_W-FRAC_W-2:0] whole;
      logic [7:0]              result;
      whole = acc[ACC_W-2:FRAC_W];
      if (acc[ACC_W-1]) begin
         result = 8'd0;
      end else if (|whole[ACC_W-FRAC_W-2:8]) begin
         result = CHAN_MAX;
      end else begin
         result = whole[7:0];
      end
      return result;
   endfunction

endpackage

### sv/yta_ifs.sv
// Channel interfaces: pixel requests, ARGB responses and register writes.
interface yta_req_if;
   logic                          valid;
   logic                          ready;
   logic [yta_pkg::SAMPLE_W-1:0]  luma;
   logic [yta_pkg::SAMPLE_W-1:0]  chroma_blue;
   logic [yta_pkg::SAMPLE_W-1:0]  chroma_red;
   modport source (output valid, luma, chroma_blue, chroma_red, input ready);
   modport sink   (input valid, luma, chroma_blue, chroma_red, output ready);
endinterface

interface yta_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [yta_pkg::ARGB_W-1:0]    argb_pixel;
   logic                          frame_done;
   logic [yta_pkg::MEAN_W-1:0]    frame_mean;
   logic                          retry_needed;
   modport source (output valid, argb_pixel, frame_done, frame_mean, retry_needed,
                   input ready);
   modport sink   (input valid, argb_pixel, frame_done, frame_mean, retry_needed,
                   output ready);
endinterface

interface yta_csr_if;
   logic                             valid;
   logic                             ready;
   logic [yta_pkg::CSR_INDEX_W-1:0]  index;
   logic [yta_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### sv/yta_front.sv
// Front end: accepts pixels, tracks row/frame position and the row luma sum.
module yta_front #(
   parameter int MAX_WIDTH  = yta_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = yta_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   output logic                                       in_ready,
   input  yta_pkg::pixel_type                         in_pixel,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]             eff_width,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]            eff_height,
   input  logic                                       queue_full,
   output logic                                       push,
   output yta_pkg::pixel_type                         push_pixel,
   output yta_pkg::pos_type                           push_pos,
   output logic [$clog2(MAX_WIDTH*yta_pkg::SAMPLE_MAX+1)-1:0] push_row_sum
);
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int RSUM_W = $clog2(MAX_WIDTH*yta_pkg::SAMPLE_MAX+1);

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [RSUM_W-1:0] rsum_ff, rsum_in;
   logic [RSUM_W-1:0] rsum_next;
   yta_pkg::pos_type  pos;

   // Position classification and next counter values
   always_comb begin
      rsum_next = rsum_ff + RSUM_W'(in_pixel.luma);
      pos.row_end = (32'(col_ff) + 32'd1) >= 32'(eff_width);
      pos.frame_end = pos.row_end && ((32'(row_ff) + 32'd1) >= 32'(eff_height));
      col_in = col_ff;
      row_in = row_ff;
      rsum_in = rsum_ff;
      if (push) begin
         if (pos.row_end) begin
            col_in = '0;
            rsum_in = '0;
            row_in = pos.frame_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
            rsum_in = rsum_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         rsum_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         rsum_ff <= rsum_in;
      end
   end

   // A transaction goes straight into the queue
   assign in_ready = !queue_full;
   assign push = in_valid && !queue_full;
   assign push_pixel = in_pixel;
   assign push_pos = pos;
   assign push_row_sum = rsum_next;

endmodule

### sv/yta_fifo.sv
// Small first-word-fall-through queue between the front and back ends.
module yta_fifo #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data
);
   localparam int DEPTH = yta_pkg::FIFO_DEPTH;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [IDX_W-1:0]  wr_ff, wr_in;
   logic [IDX_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full = cnt_ff == CNT_W'(DEPTH);
   assign pop_valid = cnt_ff != '0;
   assign pop_data = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = pop && pop_valid;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_in = do_push ? wr_ff + IDX_W'(1) : wr_ff;
      rd_in = do_pop ? rd_ff + IDX_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

### sv/yta_div.sv
// Restoring divider, one quotient bit per cycle.
module yta_div #(
   parameter int DIVIDEND_W = 20,
   parameter int DIVISOR_W  = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DIVIDEND_W+1);

   logic [DIVIDEND_W-1:0] dq_ff, dq_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // One shift-subtract step
   always_comb begin
      trial = {rem_ff, dq_ff[DIVIDEND_W-1]};
      diff = trial - {1'b0, dvs_ff};
      fits = trial >= {1'b0, dvs_ff};
      dq_in = dq_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dq_in = dividend;
         rem_in = '0;
         cnt_in = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dq_in = {dq_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff <= dq_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quotient = dq_ff;

endmodule

### sv/yta_back.sv
// Back end: color conversion, row/frame mean division and the result register.
`include "yuv_to_argb_with_brightness_check_macros.svh"

module yta_back #(
   parameter int MAX_WIDTH  = yta_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = yta_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   item_valid,
   output logic                                   item_pop,
   input  yta_pkg::pixel_type                     item_pixel,
   input  yta_pkg::pos_type                       item_pos,
   input  logic [$clog2(MAX_WIDTH*yta_pkg::SAMPLE_MAX+1)-1:0] item_row_sum,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]         eff_width,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]        eff_height,
   input  logic [yta_pkg::LIMIT_W-1:0]            dark_limit,
   input  logic [yta_pkg::LIMIT_W-1:0]            bright_limit,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [yta_pkg::ARGB_W-1:0]             rsp_argb_pixel,
   output logic                                   rsp_frame_done,
   output logic [yta_pkg::MEAN_W-1:0]             rsp_frame_mean,
   output logic                                   rsp_retry_needed
);
   localparam int RSUM_W = $clog2(MAX_WIDTH*yta_pkg::SAMPLE_MAX+1);
   localparam int FSUM_W = $clog2(MAX_HEIGHT*yta_pkg::SAMPLE_MAX+1);
   localparam int WV_W   = $clog2(MAX_WIDTH+1);
   localparam int HV_W   = $clog2(MAX_HEIGHT+1);
   localparam int DIV_W  = (RSUM_W > FSUM_W) ? RSUM_W : FSUM_W;
   localparam int DVS_W  = (WV_W > HV_W) ? WV_W : HV_W;
   localparam int PROD_W = yta_pkg::PROD_W;
   localparam int ACC_W  = yta_pkg::ACC_W;
   localparam int MEAN_W = yta_pkg::MEAN_W;

   // Product stage
   logic signed [yta_pkg::OFFS_W-1:0] yy, cb, cr;
   logic signed [PROD_W-1:0] py_ff, prv_ff, pgu_ff, pgv_ff, pbu_ff;
   yta_pkg::pos_type         s1_pos_ff;
   logic [RSUM_W-1:0]        s1_rsum_ff;
   logic                     s1_v_ff, s1_v_in;
   logic                     s1_load, consume;

   // Control and frame state
   yta_pkg::back_state_type  state_ff, state_in;
   logic [FSUM_W-1:0]        fsum_ff, fsum_in, fsum_next;
   logic [MEAN_W-1:0]        mean_ff, mean_in, div_mean;
   logic                     retry_ff, retry_in;

   // Divider hookup
   logic                     div_start, div_busy, div_done;
   logic [DIV_W-1:0]         div_dividend, div_quot;
   logic [DVS_W-1:0]         div_divisor;

   // Result register
   logic                     out_v_ff, out_v_in;
   logic [yta_pkg::ARGB_W-1:0] out_argb_ff;
   logic                     out_done_ff;
   logic [MEAN_W-1:0]        out_mean_ff;
   logic                     out_retry_ff;
   logic                     out_free, load_out;
   logic [7:0]               red, green, blue;

   // Queue pop into the product stage
   assign s1_load = !s1_v_ff || consume;
   assign item_pop = item_valid && s1_load;

   always_comb begin
      yy = $signed({2'b00, item_pixel.luma}) - yta_pkg::LUMA_OFFSET;
      cb = $signed({2'b00, item_pixel.chroma_blue}) - yta_pkg::CHROMA_OFFSET;
      cr = $signed({2'b00, item_pixel.chroma_red}) - yta_pkg::CHROMA_OFFSET;
      if (item_pop) begin
         s1_v_in = 1'b1;
      end else if (consume) begin
         s1_v_in = 1'b0;
      end else begin
         s1_v_in = s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         py_ff <= PROD_W'(yy) * yta_pkg::COEF_Y;
         prv_ff <= PROD_W'(cr) * yta_pkg::COEF_RV;
         pgu_ff <= PROD_W'(cb) * yta_pkg::COEF_GU;
         pgv_ff <= PROD_W'(cr) * yta_pkg::COEF_GV;
         pbu_ff <= PROD_W'(cb) * yta_pkg::COEF_BU;
         s1_pos_ff <= item_pos;
         s1_rsum_ff <= item_row_sum;
      end
   end

   // Channel sums and clamp
   always_comb begin
      red = yta_pkg::clamp_channel(ACC_W'(py_ff) + ACC_W'(prv_ff));
      green = yta_pkg::clamp_channel(ACC_W'(py_ff) - ACC_W'(pgu_ff) - ACC_W'(pgv_ff));
      blue = yta_pkg::clamp_channel(ACC_W'(py_ff) + ACC_W'(pbu_ff));
   end

   yta_div #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Saturated quotient and frame sum update
   always_comb begin
      div_mean = (|div_quot[DIV_W-1:MEAN_W]) ? yta_pkg::CHAN_MAX : div_quot[MEAN_W-1:0];
      fsum_next = fsum_ff + FSUM_W'(div_mean);
   end

   assign out_free = !out_v_ff || rsp_ready;

   // Sequencer: ordinary pixels pass; row ends divide, frame ends divide twice
   always_comb begin
      state_in = state_ff;
      consume = 1'b0;
      load_out = 1'b0;
      div_start = 1'b0;
      div_dividend = DIV_W'(s1_rsum_ff);
      div_divisor = DVS_W'(eff_width);
      fsum_in = fsum_ff;
      mean_in = mean_ff;
      retry_in = retry_ff;
      case (state_ff)
         yta_pkg::BS_RUN: begin
            if (s1_v_ff) begin
               if (s1_pos_ff.row_end) begin
                  div_start = 1'b1;
                  state_in = yta_pkg::BS_ROW_DIV;
               end else if (out_free) begin
                  load_out = 1'b1;
                  consume = 1'b1;
               end
            end
         end
         yta_pkg::BS_ROW_DIV: begin
            if (div_done) begin
               if (s1_pos_ff.frame_end) begin
                  div_start = 1'b1;
                  div_dividend = DIV_W'(fsum_next);
                  div_divisor = DVS_W'(eff_height);
                  fsum_in = '0;
                  state_in = yta_pkg::BS_FRAME_DIV;
               end else begin
                  fsum_in = fsum_next;
                  state_in = yta_pkg::BS_EMIT;
               end
            end
         end
         yta_pkg::BS_FRAME_DIV: begin
            if (div_done) begin
               mean_in = div_mean;
               retry_in = (div_mean < dark_limit) || (div_mean > bright_limit);
               state_in = yta_pkg::BS_EMIT;
            end
         end
         yta_pkg::BS_EMIT: begin
            if (out_free) begin
               load_out = 1'b1;
               consume = 1'b1;
               state_in = yta_pkg::BS_RUN;
            end
         end
         default: begin
            state_in = yta_pkg::BS_RUN;
         end
      endcase
   end

   always_comb begin
      if (load_out) begin
         out_v_in = 1'b1;
      end else if (rsp_ready) begin
         out_v_in = 1'b0;
      end else begin
         out_v_in = out_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= yta_pkg::BS_RUN;
         s1_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
         fsum_ff <= '0;
      end else begin
         state_ff <= state_in;
         s1_v_ff <= s1_v_in;
         out_v_ff <= out_v_in;
         fsum_ff <= fsum_in;
      end
   end

   // Frame result and response payload
   always_ff @(posedge clock) begin
      mean_ff <= mean_in;
      retry_ff <= retry_in;
      if (load_out) begin
         out_argb_ff <= {yta_pkg::ALPHA, red, green, blue};
         out_done_ff <= s1_pos_ff.frame_end;
         out_mean_ff <= s1_pos_ff.frame_end ? mean_ff : '0;
         out_retry_ff <= s1_pos_ff.frame_end && retry_ff;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_argb_pixel = out_argb_ff;
   assign rsp_frame_done = out_done_ff;
   assign rsp_frame_mean = out_mean_ff;
   assign rsp_retry_needed = out_retry_ff;

   `YTA_ASSERT_NOW(a_div_start_idle, div_start, !div_busy, "divider restarted while busy")
   `YTA_ASSERT_NOW(a_div_holds_item, (state_ff == yta_pkg::BS_ROW_DIV) || (state_ff == yta_pkg::BS_FRAME_DIV), s1_v_ff && !consume, "pixel lost during division")
   `YTA_ASSERT_NOW(a_mean_only_at_end, out_v_ff && !out_done_ff, (out_mean_ff == '0) && !out_retry_ff, "frame stats outside frame end")
   `YTA_ASSERT_NEXT(a_row_end_divides, (state_ff == yta_pkg::BS_RUN) && s1_v_ff && s1_pos_ff.row_end, (state_ff == yta_pkg::BS_ROW_DIV) && div_busy, "row end did not start division")

endmodule

### sv/yuv_to_argb_with_brightness_check.sv
// Converts limited-range BT.601 YCbCr pixels to opaque ARGB (Q2.14 coefficients,
// truncate and clamp per channel) and checks frame brightness: each row's
// truncated luma mean is summed, and on the last pixel of a frame the mean of
// the row means is reported with a retry flag when it lies below dark_limit or
// above bright_limit. An ordinary pixel passes from the queue through the
// product stage into the result register, which holds its response until it
// is taken. The pixel that closes a row holds the back end while the shared
// restoring divider produces one quotient bit per cycle; a frame-end pixel
// runs the divider twice, first for the row mean and then for the frame mean.
// A four-entry queue lets the front keep taking pixels during those divisions.
// Register writes are always ready; the geometry is used clamped to
// 1..MAX_WIDTH and 1..MAX_HEIGHT.
module yuv_to_argb_with_brightness_check #(
   parameter int MAX_WIDTH  = yta_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = yta_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   yta_req_if.sink     req_chan,
   yta_rsp_if.source   rsp_chan,
   yta_csr_if.sink     csr_chan
);
   localparam int WV_W   = $clog2(MAX_WIDTH+1);
   localparam int HV_W   = $clog2(MAX_HEIGHT+1);
   localparam int RSUM_W = $clog2(MAX_WIDTH*yta_pkg::SAMPLE_MAX+1);
   localparam int PIX_W  = $bits(yta_pkg::pixel_type);
   localparam int POS_W  = $bits(yta_pkg::pos_type);
   localparam int Q_W    = PIX_W + POS_W + RSUM_W;

   // Configuration registers
   logic [yta_pkg::DIM_W-1:0]   width_ff, width_in;
   logic [yta_pkg::DIM_W-1:0]   height_ff, height_in;
   logic [yta_pkg::LIMIT_W-1:0] dark_ff, dark_in;
   logic [yta_pkg::LIMIT_W-1:0] bright_ff, bright_in;
   logic [WV_W-1:0]             eff_width;
   logic [HV_W-1:0]             eff_height;

   // Front to queue to back
   yta_pkg::pixel_type          in_pixel, f_pixel, b_pixel;
   yta_pkg::pos_type            f_pos, b_pos;
   logic [RSUM_W-1:0]           f_rsum, b_rsum;
   logic                        push, full, pop, q_valid;
   logic [Q_W-1:0]              q_out;

   assign csr_chan.ready = 1'b1;

   // Register writes; unknown indexes are dropped
   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      dark_in = dark_ff;
      bright_in = bright_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            yta_pkg::CSR_FRAME_WIDTH:  width_in = csr_chan.data[yta_pkg::DIM_W-1:0];
            yta_pkg::CSR_FRAME_HEIGHT: height_in = csr_chan.data[yta_pkg::DIM_W-1:0];
            yta_pkg::CSR_DARK_LIMIT:   dark_in = csr_chan.data[yta_pkg::LIMIT_W-1:0];
            yta_pkg::CSR_BRIGHT_LIMIT: bright_in = csr_chan.data[yta_pkg::LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= yta_pkg::WIDTH_RESET;
         height_ff <= yta_pkg::HEIGHT_RESET;
         dark_ff <= yta_pkg::DARK_RESET;
         bright_ff <= yta_pkg::BRIGHT_RESET;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         dark_ff <= dark_in;
         bright_ff <= bright_in;
      end
   end

   // Effective geometry: zero reads as one, large values as the maximum
   always_comb begin
      if (width_ff == '0) begin
         eff_width = WV_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_width = WV_W'(MAX_WIDTH);
      end else begin
         eff_width = WV_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_height = HV_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         eff_height = HV_W'(MAX_HEIGHT);
      end else begin
         eff_height = HV_W'(height_ff);
      end
   end

   assign in_pixel.luma = req_chan.luma;
   assign in_pixel.chroma_blue = req_chan.chroma_blue;
   assign in_pixel.chroma_red = req_chan.chroma_red;

   yta_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_chan.valid),
      .in_ready     (req_chan.ready),
      .in_pixel     (in_pixel),
      .eff_width    (eff_width),
      .eff_height   (eff_height),
      .queue_full   (full),
      .push         (push),
      .push_pixel   (f_pixel),
      .push_pos     (f_pos),
      .push_row_sum (f_rsum)
   );

   yta_fifo #(
      .DATA_W (Q_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({f_pixel, f_pos, f_rsum}),
      .full      (full),
      .pop       (pop),
      .pop_valid (q_valid),
      .pop_data  (q_out)
   );

   assign {b_pixel, b_pos, b_rsum} = q_out;

   yta_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (q_valid),
      .item_pop         (pop),
      .item_pixel       (b_pixel),
      .item_pos         (b_pos),
      .item_row_sum     (b_rsum),
      .eff_width        (eff_width),
      .eff_height       (eff_height),
      .dark_limit       (dark_ff),
      .bright_limit     (bright_ff),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_argb_pixel   (rsp_chan.argb_pixel),
      .rsp_frame_done   (rsp_chan.frame_done),
      .rsp_frame_mean   (rsp_chan.frame_mean),
      .rsp_retry_needed (rsp_chan.retry_needed)
   );

endmodule

### dv/tb_yuv_to_argb_with_brightness_check.sv
// Testbench for the YUV to ARGB converter: table-driven and random pixels against a predictor.
module tb_yuv_to_argb_with_brightness_check;
   import yta_pkg::*;

   // Q2.14 conversion coefficients
   localparam int Q14_Y  = 19078;
   localparam int Q14_RV = 26149;
   localparam int Q14_GU = 6419;
   localparam int Q14_GV = 13320;
   localparam int Q14_BU = 33050;

   localparam int RANDOM_ITEMS = 1400;
   localparam int IDLE_PERCENT = 21;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 60;
   localparam int DIRECTED_N   = 24;

   typedef struct packed {
      logic [ARGB_W-1:0] argb_pixel;
      logic              frame_done;
      logic [MEAN_W-1:0] frame_mean;
      logic              retry_needed;
   } argb_result_type;

   typedef struct packed {
      pixel_type       px;
      logic            typed;
      argb_result_type known;
   } directed_row_type;

   localparam argb_result_type BLACK = '{32'hff000000, 1'b0, 8'd0, 1'b0};
   localparam argb_result_type WHITE = '{32'hffffffff, 1'b0, 8'd0, 1'b0};
   localparam argb_result_type NONE  = '0;

   logic clock;
   logic reset;

   yta_req_if req_chan();
   yta_rsp_if rsp_chan();
   yta_csr_if csr_chan();

   yuv_to_argb_with_brightness_check uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Predictor copy of registers and frame statistics
   logic [DIM_W-1:0]   cfg_width;
   logic [DIM_W-1:0]   cfg_height;
   logic [LIMIT_W-1:0] cfg_dark;
   logic [LIMIT_W-1:0] cfg_bright;
   logic [11:0]        column_pos;
   logic [11:0]        row_pos;
   logic [19:0]        row_luma_total;
   logic [19:0]        row_mean_total;

   argb_result_type  pending_results[$];
   directed_row_type directed_rows [DIRECTED_N];
   int               error_count;
   int               quiet_cycles;
   bit               steady;
   bit               hold_request;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Negative gives 0, else truncate the fraction and saturate
   function automatic logic [7:0] to_channel(input int acc);
      int whole;
      if (acc < 0) return 8'd0;
      whole = acc >>> 14;
      return (whole > 255) ? 8'd255 : 8'(whole);
   endfunction

   function automatic int effective_dim(input logic [DIM_W-1:0] v, input int limit);
      if (v == 0) return 1;
      return (int'(v) > limit) ? limit : int'(v);
   endfunction

   // Converts one pixel and advances the row/frame statistics
   function automatic argb_result_type convert_pixel(input pixel_type px);
      argb_result_type res;
      int yy, cb, cr, w, h, row_mean, mean;
      yy = int'(px.luma) - 16;
      cb = int'(px.chroma_blue) - 128;
      cr = int'(px.chroma_red) - 128;
      w = effective_dim(cfg_width, MAX_WIDTH_DEFAULT);
      h = effective_dim(cfg_height, MAX_HEIGHT_DEFAULT);
      res.argb_pixel = {8'hff,
                        to_channel(Q14_Y * yy + Q14_RV * cr),
                        to_channel(Q14_Y * yy - Q14_GU * cb - Q14_GV * cr),
                        to_channel(Q14_Y * yy + Q14_BU * cb)};
      res.frame_done = 1'b0;
      res.frame_mean = '0;
      res.retry_needed = 1'b0;
      row_luma_total = row_luma_total + 20'(px.luma);
      if (int'(column_pos) + 1 >= w) begin
         row_mean = int'(row_luma_total) / w;
         if (row_mean > 255) row_mean = 255;
         row_mean_total = row_mean_total + 20'(row_mean);
         row_luma_total = '0;
         column_pos = '0;
         if (int'(row_pos) + 1 >= h) begin
            mean = int'(row_mean_total) / h;
            if (mean > 255) mean = 255;
            res.frame_done = 1'b1;
            res.frame_mean = 8'(mean);
            res.retry_needed = (mean < int'(cfg_dark)) || (mean > int'(cfg_bright));
            row_mean_total = '0;
            row_pos = '0;
         end else begin
            row_pos = row_pos + 1'b1;
         end
      end else begin
         column_pos = column_pos + 1'b1;
      end
      return res;
   endfunction

   function automatic logic [7:0] corner_value();
      case ($urandom_range(0, 4))
         0: return 8'd0;
         1: return 8'd16;
         2: return 8'd128;
         3: return 8'd235;
         default: return 8'd255;
      endcase
   endfunction

   // mode 0: uniform, 1: luma in a band, 2: fields pulled toward corners
   function automatic pixel_type random_pixel(input int mode, input int center);
      pixel_type px;
      px = pixel_type'($urandom);
      if (mode == 1) begin
         px.luma = 8'($urandom_range((center > 10) ? center - 10 : 0,
                                     (center < 245) ? center + 10 : 255));
      end else if (mode == 2) begin
         if ($urandom_range(0, 1)) px.luma = corner_value();
         if ($urandom_range(0, 1)) px.chroma_blue = corner_value();
         if ($urandom_range(0, 1)) px.chroma_red = corner_value();
      end
      return px;
   endfunction

   // One register write; the predictor follows on acceptance
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_chan.valid = 1'b1;
      csr_chan.index = idx;
      csr_chan.data = value;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         CSR_FRAME_WIDTH:  cfg_width = value[DIM_W-1:0];
         CSR_FRAME_HEIGHT: cfg_height = value[DIM_W-1:0];
         CSR_DARK_LIMIT:   cfg_dark = value[LIMIT_W-1:0];
         CSR_BRIGHT_LIMIT: cfg_bright = value[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_release();
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   // Unused upper data bits carry random junk
   task automatic set_frame(input int w, input int h, input int dark, input int bright);
      write_reg(CSR_FRAME_WIDTH, {(CSR_DATA_W-DIM_W)'($urandom), DIM_W'(w)});
      write_reg(CSR_FRAME_HEIGHT, {(CSR_DATA_W-DIM_W)'($urandom), DIM_W'(h)});
      write_reg(CSR_DARK_LIMIT, {(CSR_DATA_W-LIMIT_W)'($urandom), LIMIT_W'(dark)});
      write_reg(CSR_BRIGHT_LIMIT, {(CSR_DATA_W-LIMIT_W)'($urandom), LIMIT_W'(bright)});
      csr_release();
   endtask

   // One pixel transaction with optional idle cycles ahead of it
   task automatic send_pixel(input pixel_type px, input logic typed,
                             input argb_result_type known);
      argb_result_type predicted;
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_chan.valid = 1'b1;
      req_chan.luma = px.luma;
      req_chan.chroma_blue = px.chroma_blue;
      req_chan.chroma_red = px.chroma_red;
      do @(posedge clock); while (!req_chan.ready);
      predicted = convert_pixel(px);
      pending_results.push_back(typed ? known : predicted);
   endtask

   // Sender pauses until every pending result has come back
   task automatic finish_phase();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_luma_run(input int count, input logic [7:0] luma);
      repeat (count) send_pixel({luma, 8'($urandom), 8'($urandom)}, 1'b0, NONE);
      finish_phase();
   endtask

   task automatic random_phase(input int count);
      int mode, center;
      mode = $urandom_range(0, 2);
      center = $urandom_range(0, 255);
      repeat (count) send_pixel(random_pixel(mode, center), 1'b0, NONE);
      finish_phase();
   endtask

   // Response ready, with one long hold-off on request
   always begin
      @(negedge clock);
      if (hold_request) begin
         hold_request = 1'b0;
         rsp_chan.ready = 1'b0;
         repeat (HOLD_CYCLES) @(negedge clock);
      end
      rsp_chan.ready = steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Compare each response transaction with the oldest prediction
   always @(posedge clock) begin
      argb_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual argb_pixel %h",
                     $time, rsp_chan.argb_pixel);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.argb_pixel !== want.argb_pixel) begin
               $display("%0t: argb_pixel expected %h actual %h",
                        $time, want.argb_pixel, rsp_chan.argb_pixel);
               error_count++;
            end
            if (rsp_chan.frame_done !== want.frame_done) begin
               $display("%0t: frame_done expected %0d actual %0d",
                        $time, want.frame_done, rsp_chan.frame_done);
               error_count++;
            end
            if (rsp_chan.frame_mean !== want.frame_mean) begin
               $display("%0t: frame_mean expected %0d actual %0d",
                        $time, want.frame_mean, rsp_chan.frame_mean);
               error_count++;
            end
            if (rsp_chan.retry_needed !== want.retry_needed) begin
               $display("%0t: retry_needed expected %0d actual %0d",
                        $time, want.retry_needed, rsp_chan.retry_needed);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      int random_sent, phase, batch, w, h, dark, bright, pick;
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.luma = '0;
      req_chan.chroma_blue = '0;
      req_chan.chroma_red = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
      steady = 1'b0;
      hold_request = 1'b0;
      error_count = 0;
      quiet_cycles = 0;
      cfg_width = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      cfg_dark = DARK_RESET;
      cfg_bright = BRIGHT_RESET;
      column_pos = '0;
      row_pos = '0;
      row_luma_total = '0;
      row_mean_total = '0;

      // 2x2 frames: black, white, field extremes, chroma swings, dark and bright edges
      directed_rows = '{
         '{'{8'd16, 8'd128, 8'd128}, 1'b1, BLACK},
         '{'{8'd16, 8'd128, 8'd128}, 1'b1, BLACK},
         '{'{8'd16, 8'd128, 8'd128}, 1'b1, BLACK},
         '{'{8'd16, 8'd128, 8'd128}, 1'b1, '{32'hff000000, 1'b1, 8'd16, 1'b1}},
         '{'{8'd235, 8'd128, 8'd128}, 1'b1, WHITE},
         '{'{8'd235, 8'd128, 8'd128}, 1'b1, WHITE},
         '{'{8'd235, 8'd128, 8'd128}, 1'b1, WHITE},
         '{'{8'd235, 8'd128, 8'd128}, 1'b1, '{32'hffffffff, 1'b1, 8'd235, 1'b1}},
         '{'{8'd255, 8'd255, 8'd255}, 1'b0, NONE},
         '{'{8'd0, 8'd0, 8'd0}, 1'b0, NONE},
         '{'{8'd255, 8'd0, 8'd255}, 1'b0, NONE},
         '{'{8'd0, 8'd255, 8'd0}, 1'b0, NONE},
         '{'{8'd128, 8'd0, 8'd255}, 1'b0, NONE},
         '{'{8'd128, 8'd255, 8'd0}, 1'b0, NONE},
         '{'{8'd100, 8'd128, 8'd200}, 1'b0, NONE},
         '{'{8'd200, 8'd50, 8'd128}, 1'b0, NONE},
         '{'{8'd32, 8'd128, 8'd128}, 1'b0, NONE},
         '{'{8'd32, 8'd128, 8'd128}, 1'b0, NONE},
         '{'{8'd32, 8'd128, 8'd128}, 1'b0, NONE},
         '{'{8'd32, 8'd128, 8'd128}, 1'b0, NONE},
         '{'{8'd223, 8'd128, 8'd128}, 1'b0, NONE},
         '{'{8'd223, 8'd128, 8'd128}, 1'b0, NONE},
         '{'{8'd223, 8'd128, 8'd128}, 1'b0, NONE},
         '{'{8'd223, 8'd128, 8'd128}, 1'b0, NONE}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table
      set_frame(2, 2, 32, 223);
      foreach (directed_rows[i])
         send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].known);
      finish_phase();

      // Writes to unused indexes must not disturb anything
      for (int idx = 4; idx < 16; idx++) write_reg(CSR_INDEX_W'(idx), CSR_DATA_W'($urandom));
      csr_release();
      repeat (4) send_pixel(random_pixel(0, 0), 1'b0, NONE);
      finish_phase();

      // Oversized width used as the maximum, partial row, then width 0 ends it (mean saturates)
      set_frame(8191, 1, 32, 223);
      send_luma_run(80, 8'd255);
      set_frame(0, 1, 32, 223);
      send_luma_run(3, 8'd255);

      // Oversized height, then height 0 ends the frame mid-way (frame mean saturates)
      set_frame(1, 8191, 32, 223);
      send_luma_run(20, 8'd200);
      set_frame(1, 0, 0, 0);
      send_luma_run(2, 8'd200);

      // Random phases with random geometry and limits
      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         w = (pick < 60) ? $urandom_range(1, 4) : (pick < 85) ? $urandom_range(5, 16) :
             (pick < 95) ? $urandom_range(17, 64) : 0;
         pick = $urandom_range(0, 99);
         h = (pick < 70) ? $urandom_range(1, 4) : (pick < 90) ? $urandom_range(5, 8) : 0;
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            dark = 0;
            bright = 255;
         end else if (pick < 30) begin
            dark = 255;
            bright = 0;
         end else begin
            dark = $urandom_range(0, 160);
            bright = $urandom_range(dark, 255);
         end
         set_frame(w, h, dark, bright);
         if (phase % 5 == 4) begin
            write_reg(CSR_INDEX_W'($urandom_range(4, 15)), CSR_DATA_W'($urandom));
            csr_release();
         end
         // phase 1 fills the block behind a long response hold-off; phase 3 runs without gaps
         steady = (phase == 1) || (phase == 3);
         hold_request = (phase == 1);
         batch = steady ? 150 : $urandom_range(30, 100);
         random_phase(batch);
         random_sent += batch;
         steady = 1'b0;
         phase++;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
